### hw/rtl/lbbc_pkg.sv
// Shared types, widths and codes for the LRU block buffer cache.
package lbbc_pkg;

  localparam int DEF_NUM_BUFFERS = 32;

  localparam int DEV_W    = 8;
  localparam int BLK_W    = 32;
  localparam int CNT_W    = 8;
  localparam int IDX_W    = 5;
  localparam int STATUS_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOBUF  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RELERR = 2'd2;

  // What the update cycle does to the cell row
  typedef enum logic [2:0] {
    KIND_HIT,
    KIND_MISS,
    KIND_NOBUF,
    KIND_REL,
    KIND_RELMOVE,
    KIND_RELERR
  } kind_t;

  // Per-buffer contents that travel with a slot along the row
  typedef struct packed {
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
    logic             valid;
    logic [CNT_W-1:0] cnt;
  } cell_data_t;

  // Compare results registered in each cell
  typedef struct packed {
    logic match;
    logic free;
    logic rel_hit;
    logic rel_zero;
    logic rel_one;
  } cell_flags_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic  cmp;
    logic  upd;
    kind_t kind;
  } cell_ctl_t;

endpackage

### hw/rtl/lru_block_buffer_cache.sv
// Top level of the LRU block buffer cache: cell row plus request sequencer.
//
// Usage:
//   Requests enter on the s_ stream: tuser[0] is the operation (0 get,
//   1 release), tdata carries device, block number and release index.
//   Each request gives exactly one result word on the m_ stream: tdata
//   carries the buffer index, hit and needs-fill flags, tuser the status
//   (0 ok, 1 no free buffer, 2 release of an unreferenced buffer).
//   The buffers sit in a row of cells ordered by recency, position 0 most
//   recent; each cell carries its slot id and tags so a move to the front
//   is a one-step shift of the row toward the tail.
// Sequence:
//   Each request steps through accept, parallel tag/count compare in every
//   cell, priority pick of the target position, then the row update that also
//   loads the result register; no new request is accepted before that update.
//   The next request is taken while a result still waits in the output
//   register; the update cycle waits only if that register is still full.
// Reset:
//   rst (synchronous) clears all tags, valid bits and counts, sets the
//   highest slot most recent and slot zero least, and empties the output.
//   A stalled m_tready holds the result word steady until it is taken.
module lru_block_buffer_cache #(
  parameter int NUM_BUFFERS = lbbc_pkg::DEF_NUM_BUFFERS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // device[7:0], block_number[39:8], release_index[44:40]
  input  logic [0:0]  s_tuser,   // operation[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // buffer_index[4:0], hit[5], needs_fill[6]
  output logic [1:0]  m_tuser    // status[1:0]
);

  localparam int NB     = NUM_BUFFERS;
  localparam int SLOT_W = (NB > 1) ? $clog2(NB) : 1;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_SEL, S_UPD} state_t;

  state_t state;

  // Latched request
  logic                          op_q;
  logic [lbbc_pkg::DEV_W-1:0]    dev_q;
  logic [lbbc_pkg::BLK_W-1:0]    blk_q;
  logic [lbbc_pkg::IDX_W-1:0]    rel_q;

  // Pick results
  lbbc_pkg::kind_t kind_q;
  logic [NB-1:0]   tgt_q;
  logic [NB-1:0]   shift_q;

  // Row
  lbbc_pkg::cell_data_t  cdata  [NB];
  logic [SLOT_W-1:0]     cslot  [NB];
  lbbc_pkg::cell_flags_t cflags [NB];
  lbbc_pkg::cell_ctl_t   ctl;
  lbbc_pkg::cell_data_t  front_data;
  logic [SLOT_W-1:0]     front_slot;
  logic [SLOT_W-1:0]     rel_slot;

  logic out_free;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);
  assign rel_slot = SLOT_W'(rel_q);

  assign ctl.cmp  = (state == S_CMP);
  assign ctl.upd  = (state == S_UPD) && out_free;
  assign ctl.kind = kind_q;

  // Target contents; on a move they land at the head with a zero count
  always_comb begin
    front_data = '0;
    front_slot = '0;
    for (int i = 0; i < NB; i++) begin
      if (tgt_q[i]) begin
        front_data = front_data | cdata[i];
        front_slot = front_slot | cslot[i];
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < NB; g++) begin : g_cell
      lbbc_pkg::cell_data_t nb_d;
      logic [SLOT_W-1:0]    nb_s;
      if (g == 0) begin : g_head
        always_comb begin
          nb_d     = front_data;
          nb_d.cnt = '0;
          nb_s     = front_slot;
        end
      end else begin : g_body
        assign nb_d = cdata[g-1];
        assign nb_s = cslot[g-1];
      end
      lbbc_cell #(
        .SLOT_W     (SLOT_W),
        .RESET_SLOT (NB - 1 - g)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .req_dev  (dev_q),
        .req_blk  (blk_q),
        .rel_slot (rel_slot),
        .tgt      (tgt_q[g]),
        .shift    (shift_q[g]),
        .nb_data  (nb_d),
        .nb_slot  (nb_s),
        .data     (cdata[g]),
        .slot     (cslot[g]),
        .flags    (cflags[g])
      );
    end
  endgenerate

  // Pick: first match from the head, last free toward the tail
  logic [NB-1:0]   match_v, free_v, free_r, relhit_v, relzero_v, relone_v;
  logic [NB-1:0]   hit_oh, free_oh_r, free_oh, pick_oh;
  logic            rel_range_bad, rel_bad;
  lbbc_pkg::kind_t pick_kind;

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      match_v[i]   = cflags[i].match;
      free_v[i]    = cflags[i].free;
      relhit_v[i]  = cflags[i].rel_hit;
      relzero_v[i] = cflags[i].rel_zero;
      relone_v[i]  = cflags[i].rel_one;
      free_r[i]    = cflags[NB-1-i].free;
    end
    hit_oh    = match_v & (~match_v + NB'(1));
    free_oh_r = free_r & (~free_r + NB'(1));
    for (int i = 0; i < NB; i++) begin
      free_oh[i] = free_oh_r[NB-1-i];
    end
    rel_range_bad = (32'(rel_q) >= 32'(NB));
    rel_bad       = rel_range_bad || !(|relhit_v) || (|relzero_v);
    if (!op_q) begin
      if (|match_v) begin
        pick_kind = lbbc_pkg::KIND_HIT;
        pick_oh   = hit_oh;
      end else if (|free_v) begin
        pick_kind = lbbc_pkg::KIND_MISS;
        pick_oh   = free_oh;
      end else begin
        pick_kind = lbbc_pkg::KIND_NOBUF;
        pick_oh   = '0;
      end
    end else begin
      pick_oh = rel_bad ? '0 : relhit_v;
      if (rel_bad) pick_kind = lbbc_pkg::KIND_RELERR;
      else if (|relone_v) pick_kind = lbbc_pkg::KIND_RELMOVE;
      else pick_kind = lbbc_pkg::KIND_REL;
    end
  end

  // Result fields from the target before it is updated
  logic                            tgt_valid;
  logic [lbbc_pkg::IDX_W-1:0]      res_idx;
  logic [lbbc_pkg::STATUS_W-1:0]   res_status;
  logic                            res_hit, res_fill;

  always_comb begin
    tgt_valid = 1'b0;
    for (int i = 0; i < NB; i++) begin
      tgt_valid = tgt_valid | (tgt_q[i] & cdata[i].valid);
    end
    res_idx    = rel_q;
    res_status = lbbc_pkg::ST_OK;
    res_hit    = 1'b0;
    res_fill   = 1'b0;
    unique case (kind_q)
      lbbc_pkg::KIND_HIT: begin
        res_idx  = lbbc_pkg::IDX_W'(front_slot);
        res_hit  = 1'b1;
        res_fill = !tgt_valid;
      end
      lbbc_pkg::KIND_MISS: begin
        res_idx  = lbbc_pkg::IDX_W'(front_slot);
        res_fill = 1'b1;
      end
      lbbc_pkg::KIND_NOBUF: begin
        res_idx    = '0;
        res_status = lbbc_pkg::ST_NOBUF;
      end
      lbbc_pkg::KIND_RELERR: res_status = lbbc_pkg::ST_RELERR;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // in the update cycle a taken word is replaced at once
      if (m_tvalid && m_tready && state != S_UPD) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_q  <= s_tuser[0];
            dev_q <= s_tdata[7:0];
            blk_q <= s_tdata[39:8];
            rel_q <= s_tdata[44:40];
            state <= S_CMP;
          end
        end
        S_CMP: state <= S_SEL;
        S_SEL: begin
          kind_q  <= pick_kind;
          tgt_q   <= pick_oh;
          shift_q <= pick_oh | (pick_oh - NB'(1));
          state   <= S_UPD;
        end
        S_UPD: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, res_fill, res_hit, res_idx};
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/lbbc_cell.sv
// One recency position of the buffer row: slot id, tags, valid and count.
module lbbc_cell #(
  parameter int SLOT_W     = 5,
  parameter int RESET_SLOT = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lbbc_pkg::cell_ctl_t   ctl,
  input  logic [lbbc_pkg::DEV_W-1:0] req_dev,
  input  logic [lbbc_pkg::BLK_W-1:0] req_blk,
  input  logic [SLOT_W-1:0]     rel_slot,
  input  logic                  tgt,        // this position is the target
  input  logic                  shift,      // take neighbor contents on a move
  input  lbbc_pkg::cell_data_t  nb_data,
  input  logic [SLOT_W-1:0]     nb_slot,
  output lbbc_pkg::cell_data_t  data,
  output logic [SLOT_W-1:0]     slot,
  output lbbc_pkg::cell_flags_t flags
);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot  <= SLOT_W'(RESET_SLOT);
      data  <= '0;
      flags <= '0;
    end else begin
      if (ctl.cmp) begin
        flags.match    <= (data.dev == req_dev) && (data.blk == req_blk);
        flags.free     <= (data.cnt == '0);
        flags.rel_hit  <= (slot == rel_slot);
        flags.rel_zero <= (slot == rel_slot) && (data.cnt == '0);
        flags.rel_one  <= (slot == rel_slot) && (data.cnt == lbbc_pkg::CNT_W'(1));
      end
      if (ctl.upd) begin
        unique case (ctl.kind)
          lbbc_pkg::KIND_HIT: begin
            if (tgt) begin
              data.valid <= 1'b1;
              if (data.cnt != lbbc_pkg::CNT_MAX) data.cnt <= data.cnt + 1'b1;
            end
          end
          lbbc_pkg::KIND_MISS: begin
            if (tgt) begin
              data.dev   <= req_dev;
              data.blk   <= req_blk;
              data.valid <= 1'b1;
              data.cnt   <= lbbc_pkg::CNT_W'(1);
            end
          end
          lbbc_pkg::KIND_REL: begin
            if (tgt) data.cnt <= data.cnt - 1'b1;
          end
          lbbc_pkg::KIND_RELMOVE: begin
            if (shift) begin
              data <= nb_data;
              slot <= nb_slot;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

### bench/lru_block_buffer_cache_tb.sv
// Self-checking testbench for the LRU block buffer cache, predictor-based.
`timescale 1ns / 1ps

module lru_block_buffer_cache_tb;
  import lbbc_pkg::*;

  localparam int NBUF           = DEF_NUM_BUFFERS;
  localparam int POOL_SIZE      = 24;
  localparam int RANDOM_PER_RUN = 160;
  localparam int DRAIN_CYCLES   = 20;
  // No word moves on either side for this many cycles -> hang
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_REL = 1'b1;

  // One result word, field by field
  typedef struct packed {
    logic [IDX_W-1:0]    idx;
    logic [STATUS_W-1:0] status;
    logic                hit;
    logic                fill;
  } cache_result_t;

  // Directed stimulus row; exp is used only when has_exp is set
  typedef struct {
    logic          op;
    logic [7:0]    dev;
    logic [31:0]   blk;
    logic [4:0]    rel;
    bit            has_exp;
    cache_result_t exp;
  } stim_row_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;  // device[7:0], block_number[39:8], release_index[44:40]
  logic [0:0]  s_tuser  = '0;  // operation[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // buffer_index[4:0], hit[5], needs_fill[6]
  logic [1:0]  m_tuser;        // status[1:0]

  lru_block_buffer_cache #(.NUM_BUFFERS(NBUF)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Cache predictor: own copy of tags, valid bits, counts and recency list
  // (position 0 = most recent).
  // ---------------------------------------------------------------------
  logic [DEV_W-1:0] bc_dev   [NBUF];
  logic [BLK_W-1:0] bc_blk   [NBUF];
  logic             bc_valid [NBUF];
  logic [CNT_W-1:0] bc_refs  [NBUF];
  logic [IDX_W-1:0] bc_order [NBUF];

  function automatic void reset_buffer_cache();
    for (int i = 0; i < NBUF; i++) begin
      bc_dev[i]   = '0;
      bc_blk[i]   = '0;
      bc_valid[i] = 1'b0;
      bc_refs[i]  = '0;
      bc_order[i] = IDX_W'(NBUF - 1 - i);
    end
  endfunction

  function automatic cache_result_t apply_request(input logic op, input logic [7:0] dev,
                                                  input logic [31:0] blk, input logic [4:0] rel);
    cache_result_t    r;
    int               found;
    int               slot;
    logic [IDX_W-1:0] s;
    r     = '0;
    found = -1;
    if (op == OP_GET) begin
      // tag search, most recent first; valid bit plays no part in the match
      for (int pos = 0; pos < NBUF; pos++) begin
        s = bc_order[pos];
        if (found < 0 && bc_dev[s] == dev && bc_blk[s] == blk) found = int'(s);
      end
      if (found >= 0) begin
        slot = found;
        if (bc_refs[slot] != CNT_MAX) bc_refs[slot] = bc_refs[slot] + 1'b1;
        r.fill = !bc_valid[slot];
        bc_valid[slot] = 1'b1;
        r.idx    = IDX_W'(slot);
        r.status = ST_OK;
        r.hit    = 1'b1;
        // a hit leaves the recency list alone
      end else begin
        // victim: least recent unreferenced slot
        for (int pos = NBUF - 1; pos >= 0; pos--) begin
          s = bc_order[pos];
          if (found < 0 && bc_refs[s] == '0) found = int'(s);
        end
        if (found >= 0) begin
          slot = found;
          bc_dev[slot]   = dev;
          bc_blk[slot]   = blk;
          bc_refs[slot]  = CNT_W'(1);
          bc_valid[slot] = 1'b1;
          r.idx    = IDX_W'(slot);
          r.status = ST_OK;
          r.fill   = 1'b1;
        end else begin
          r.status = ST_NOBUF;
        end
      end
    end else begin
      r.idx = rel;
      if (int'(rel) >= NBUF || bc_refs[rel] == '0) begin
        r.status = ST_RELERR;
      end else begin
        r.status = ST_OK;
        bc_refs[rel] = bc_refs[rel] - 1'b1;
        if (bc_refs[rel] == '0) begin
          // last reference gone: slot becomes most recent
          for (int pos = 0; pos < NBUF; pos++) begin
            if (found < 0 && bc_order[pos] == rel) found = pos;
          end
          for (int p = found; p > 0; p--) bc_order[p] = bc_order[p - 1];
          bc_order[0] = rel;
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Scoreboard
  // ---------------------------------------------------------------------
  cache_result_t pending_results[$];
  int            fail_count    = 0;
  int            stall_cycles  = 0;
  int            send_idle_pct = 27;
  int            recv_idle_pct = 48;

  // Receiver: random back-pressure on the result stream
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every result word taken against the oldest prediction
  always @(posedge clk) begin
    cache_result_t want;
    cache_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[4:0], m_tuser, m_tdata[5], m_tdata[6]};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word: expected none,", $time,
                 " got idx=%0d status=%0d hit=%0d fill=%0d",
                 got.idx, got.status, got.hit, got.fill);
        fail_count = fail_count + 1;
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          $display("%0t: mismatch: expected idx=%0d status=%0d hit=%0d fill=%0d,",
                   $time, want.idx, want.status, want.hit, want.fill,
                   " got idx=%0d status=%0d hit=%0d fill=%0d",
                   got.idx, got.status, got.hit, got.fill);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  // Watchdog: cycles in which no word moved on either stream
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("%0t: watchdog expired, %0d results outstanding", $time, pending_results.size());
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Request driver. Holds the word until taken, then records the expected
  // result (typed-in value if given, predictor otherwise; the predictor is
  // always stepped so its state follows the block).
  // ---------------------------------------------------------------------
  task automatic send_req(input logic op, input logic [7:0] dev, input logic [31:0] blk,
                          input logic [4:0] rel, input bit has_exp,
                          input cache_result_t exp_res, output cache_result_t pred);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, rel, blk, dev};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = apply_request(op, dev, blk, rel);
    pending_results.push_back(has_exp ? exp_res : pred);
  endtask

  stim_row_t   dir_rows[$];
  logic [7:0]  pool_dev[POOL_SIZE];
  logic [31:0] pool_blk[POOL_SIZE];

  function automatic void add_row(input logic op, input logic [7:0] dev, input logic [31:0] blk,
                                  input logic [4:0] rel, input bit has_exp,
                                  input cache_result_t exp_res);
    stim_row_t row;
    row.op      = op;
    row.dev     = dev;
    row.blk     = blk;
    row.rel     = rel;
    row.has_exp = has_exp;
    row.exp     = exp_res;
    dir_rows.push_back(row);
  endfunction

  // Random mix: mostly gets from a small tag pool (hits, shared refs) and
  // releases of held slots; the rest fresh tags and blind releases.
  task automatic run_random_mix(input int n);
    cache_result_t unused;
    int            held[$];
    int            k;
    int            pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        k = $urandom_range(POOL_SIZE - 1);
        send_req(OP_GET, pool_dev[k], pool_blk[k], 5'($urandom), 1'b0, '0, unused);
      end else if (pick < 50) begin
        send_req(OP_GET, 8'($urandom), $urandom, 5'($urandom), 1'b0, '0, unused);
      end else if (pick < 90) begin
        held.delete();
        for (int s = 0; s < NBUF; s++) if (bc_refs[s] != '0) held.push_back(s);
        k = (held.size() > 0) ? held[$urandom_range(held.size() - 1)] : $urandom_range(NBUF - 1);
        send_req(OP_REL, 8'($urandom), $urandom, 5'(k), 1'b0, '0, unused);
      end else begin
        send_req(OP_REL, 8'($urandom), $urandom, 5'($urandom), 1'b0, '0, unused);
      end
    end
  endtask

  initial begin
    cache_result_t pred;
    logic [4:0]    sat_slot;
    reset_buffer_cache();

    // Tag pool for the random part; two entries sit at the field extremes
    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_dev[k] = 8'($urandom);
      pool_blk[k] = $urandom;
    end
    pool_dev[0] = 8'h00; pool_blk[0] = 32'h0000_0000;
    pool_dev[1] = 8'hFF; pool_blk[1] = 32'hFFFF_FFFF;

    // Directed table; expectations typed only where obvious from reset state
    // after reset all tags are (0,0): first get hits slot 31, still invalid
    add_row(OP_GET, 8'h00, 32'h0000_0000, 5'h1F, 1'b1, {5'd31, ST_OK, 1'b1, 1'b1});
    add_row(OP_GET, 8'h00, 32'h0000_0000, 5'h00, 1'b1, {5'd31, ST_OK, 1'b1, 1'b0});
    // release of an unreferenced slot
    add_row(OP_REL, 8'hFF, 32'hFFFF_FFFF, 5'd0,  1'b1, {5'd0,  ST_RELERR, 1'b0, 1'b0});
    // miss takes least recent free slot: slot 0
    add_row(OP_GET, 8'hFF, 32'hFFFF_FFFF, 5'h00, 1'b1, {5'd0,  ST_OK, 1'b0, 1'b1});
    add_row(OP_GET, 8'hFF, 32'hFFFF_FFFF, 5'h1F, 1'b1, {5'd0,  ST_OK, 1'b1, 1'b0});
    add_row(OP_GET, 8'h80, 32'h8000_0000, 5'h10, 1'b1, {5'd1,  ST_OK, 1'b0, 1'b1});
    // count to zero: slot 1 moves to the front
    add_row(OP_REL, 8'h00, 32'h0000_0000, 5'd1,  1'b1, {5'd1,  ST_OK, 1'b0, 1'b0});
    add_row(OP_GET, 8'h01, 32'h0000_0001, 5'h0F, 1'b0, '0);
    // released slot keeps its tag and content: hit, no fill
    add_row(OP_GET, 8'h80, 32'h8000_0000, 5'h15, 1'b0, '0);
    add_row(OP_REL, 8'h5A, 32'h1234_5678, 5'd31, 1'b1, {5'd31, ST_OK, 1'b0, 1'b0});
    add_row(OP_REL, 8'hA5, 32'h8765_4321, 5'd31, 1'b1, {5'd31, ST_OK, 1'b0, 1'b0});
    add_row(OP_REL, 8'hFF, 32'hFFFF_FFFF, 5'd31, 1'b1, {5'd31, ST_RELERR, 1'b0, 1'b0});
    // many slots still carry (0,0): most recent match wins, no reorder
    add_row(OP_GET, 8'h00, 32'h0000_0000, 5'h0A, 1'b0, '0);
    add_row(OP_GET, 8'h00, 32'h0000_0000, 5'h1F, 1'b0, '0);
    add_row(OP_GET, 8'h55, 32'hAAAA_AAAA, 5'h15, 1'b0, '0);
    add_row(OP_GET, 8'hAA, 32'h5555_5555, 5'h0A, 1'b0, '0);
    add_row(OP_REL, 8'h00, 32'h0000_0000, 5'd0,  1'b0, '0);
    add_row(OP_REL, 8'h00, 32'h0000_0000, 5'd0,  1'b0, '0);
    add_row(OP_REL, 8'h3C, 32'hC3C3_C3C3, 5'd0,  1'b1, {5'd0,  ST_RELERR, 1'b0, 1'b0});
    add_row(OP_REL, 8'h00, 32'h0000_0000, 5'd2,  1'b0, '0);
    // partial tag matches must miss
    add_row(OP_GET, 8'hFF, 32'h7FFF_FFFF, 5'h00, 1'b0, '0);
    add_row(OP_GET, 8'h7F, 32'hFFFF_FFFF, 5'h00, 1'b0, '0);
    add_row(OP_REL, 8'hFF, 32'hFFFF_FFFF, 5'd16, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Run 1: sender idles 27%, receiver 48%
    send_idle_pct = 27;
    recv_idle_pct = 48;
    foreach (dir_rows[i])
      send_req(dir_rows[i].op, dir_rows[i].dev, dir_rows[i].blk, dir_rows[i].rel,
               dir_rows[i].has_exp, dir_rows[i].exp, pred);

    // Exhaustion: fresh tags until every slot is held, then no-buffer
    for (int i = 0; i < NBUF + 2; i++)
      send_req(OP_GET, 8'hC0 ^ 8'(i), 32'hDEAD_0000 + 32'(i), 5'($urandom), 1'b0, '0, pred);
    // a hit still works while full
    send_req(OP_GET, 8'hC0, 32'hDEAD_0000, 5'($urandom), 1'b0, '0, pred);
    for (int s = 0; s < NBUF; s++)
      while (bc_refs[s] != '0) send_req(OP_REL, 8'($urandom), $urandom, 5'(s), 1'b0, '0, pred);

    // Saturation: count sticks at max, then walk it back down past zero
    send_req(OP_GET, 8'h9E, 32'h0BAD_F00D, 5'($urandom), 1'b0, '0, pred);
    sat_slot = pred.idx;
    for (int i = 0; i < 260; i++)
      send_req(OP_GET, 8'h9E, 32'h0BAD_F00D, 5'($urandom), 1'b0, '0, pred);
    while (bc_refs[sat_slot] != '0)
      send_req(OP_REL, 8'($urandom), $urandom, sat_slot, 1'b0, '0, pred);
    send_req(OP_REL, 8'($urandom), $urandom, sat_slot, 1'b0, '0, pred);

    run_random_mix(RANDOM_PER_RUN);

    // Run 2: idling swapped
    send_idle_pct = 48;
    recv_idle_pct = 27;
    run_random_mix(RANDOM_PER_RUN);

    // Run 3: full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_mix(RANDOM_PER_RUN);

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### lru_block_buffer_cache.f
hw/rtl/lbbc_pkg.sv
hw/rtl/lbbc_cell.sv
hw/rtl/lru_block_buffer_cache.sv
bench/lru_block_buffer_cache_tb.sv
